FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the watchdog RTL.
// They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("watchdog assertion failed");

// A consequence that must hold in the cycle after its trigger.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("watchdog assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: sv/mcsw_pkg.sv
// ----------------------------------------------------------------------------
// Watchdog package
// Types and codes shared by the watchdog channels and modules.
// ----------------------------------------------------------------------------
package mcsw_pkg;

  localparam int WORD_W   = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int EXPCNT_W = 4;

  typedef logic [WORD_W-1:0] word_t;

  // Request actions.
  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE = 3'd0,
    ACT_FEED   = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_CHECK  = 3'd3,
    ACT_TICK   = 3'd4
  } action_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_BAD_TIMEOUT = 2'd1,
    ST_FULL        = 2'd2,
    ST_NOT_FOUND   = 2'd3
  } status_t;

  // Expired count saturates here.
  localparam logic [EXPCNT_W-1:0] EXP_CNT_MAX = 4'hF;

  // One slot as seen by the slot evaluator.
  typedef struct packed {
    logic  valid;
    word_t id;
    word_t timeout;
    word_t fed_at;
  } slot_view_t;

  // Evaluator verdicts for one slot.
  typedef struct packed {
    logic id_match;
    logic expired;
  } slot_eval_t;

endpackage

FILE: sv/mcsw_req_if.sv
// ----------------------------------------------------------------------------
// Watchdog request channel
// Valid/ready channel carrying one watchdog command.
// ----------------------------------------------------------------------------
interface mcsw_req_if import mcsw_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  word_t               target_id;
  word_t               timeout_len;

  modport source (output valid, output action, output target_id, output timeout_len,
                  input ready);
  modport sink   (input valid, input action, input target_id, input timeout_len,
                  output ready);

endinterface

FILE: sv/mcsw_rsp_if.sv
// ----------------------------------------------------------------------------
// Watchdog result channel
// Valid/ready channel carrying one result per command.
// ----------------------------------------------------------------------------
interface mcsw_rsp_if import mcsw_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  word_t               new_id;
  logic [EXPCNT_W-1:0] expired_count;
  word_t               expired_id;

  modport source (output valid, output status, output new_id, output expired_count,
                  output expired_id, input ready);
  modport sink   (input valid, input status, input new_id, input expired_count,
                  input expired_id, output ready);

endinterface

FILE: sv/mcsw_slot_eval.sv
// ----------------------------------------------------------------------------
// Watchdog slot evaluator
// Shared compare unit applied to one slot per cycle during a table scan:
// id match for feed and delete, and the modular elapsed-time test for check.
// ----------------------------------------------------------------------------
module mcsw_slot_eval import mcsw_pkg::*; (
  input  slot_view_t slot_i,
  input  word_t      target_id_i,
  input  word_t      now_i,
  output slot_eval_t eval_o
);

  word_t elapsed;

  // Elapsed time wraps modulo the counter width.
  assign elapsed = now_i - slot_i.fed_at;

  assign eval_o.id_match = slot_i.valid && (slot_i.id == target_id_i);
  assign eval_o.expired  = slot_i.valid && (elapsed >= slot_i.timeout);

endmodule

FILE: sv/multi_channel_soft_watchdog.sv
// ----------------------------------------------------------------------------
// Multi-channel soft watchdog
// A table of NUM_CHANNELS watchdog channels sharing one 32-bit tick counter.
// Every request returns exactly one result. Create, tick and unused actions
// go straight from S_IDLE to S_DONE. Feed, delete and check walk the table
// one slot per cycle through a single shared slot evaluator fed by the
// registered read port of the slot memories, then go to S_DONE, which loads
// the output register once it is free. The block takes no request while one
// is in progress; a finished result waits in the output register. Feed and
// delete act on the newest channel holding the id; check reports the newest
// expired channel and a count saturating at 15.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_channel_soft_watchdog import mcsw_pkg::*; #(
  parameter int NUM_CHANNELS = 8
) (
  input logic       clk,
  input logic       rst_n,
  mcsw_req_if.sink  in_req,
  mcsw_rsp_if.source out_rsp
);

  localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SCNT_W = $clog2(NUM_CHANNELS + 1);
  localparam logic [SCNT_W-1:0] SCAN_LAST = SCNT_W'(NUM_CHANNELS);
  localparam logic [SCNT_W-1:0] SCNT_ONE  = SCNT_W'(1);
  localparam logic [IDX_W-1:0]  AGE_ONE   = IDX_W'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Control state.
  state_t                  state_r;
  logic [ACTION_W-1:0]     op_r;
  word_t                   target_r;
  word_t                   now_r;
  word_t                   next_id_r;
  logic [NUM_CHANNELS-1:0] valid_r;
  logic [IDX_W-1:0]        age_r [NUM_CHANNELS];

  // Slot memories.
  word_t id_mem   [NUM_CHANNELS];
  word_t tmo_mem  [NUM_CHANNELS];
  word_t feed_mem [NUM_CHANNELS];

  // Scan pipeline.
  logic [SCNT_W-1:0] scan_cnt_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              rd_valid_bit_r;
  logic [IDX_W-1:0]  rd_age_r;
  word_t             rd_id_r;
  word_t             rd_tmo_r;
  word_t             rd_feed_r;

  // Running best match and expired count.
  logic                best_hit_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [IDX_W-1:0]    best_age_r;
  word_t               best_id_r;
  logic [EXPCNT_W-1:0] exp_cnt_r;
  logic                best_hit_nxt;
  logic [IDX_W-1:0]    best_idx_nxt;
  logic [IDX_W-1:0]    best_age_nxt;
  word_t               best_id_nxt;
  logic [EXPCNT_W-1:0] exp_cnt_nxt;

  // Pending result and output register.
  status_t             res_status_r;
  word_t               res_new_id_r;
  logic [EXPCNT_W-1:0] res_cnt_r;
  word_t               res_eid_r;
  logic                out_valid_r;
  status_t             out_status_r;
  word_t               out_new_id_r;
  logic [EXPCNT_W-1:0] out_cnt_r;
  word_t               out_eid_r;

  logic             in_fire;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             create_ok;
  logic             scan_end;
  logic             hit;
  logic             take;
  logic             feed_we;
  logic [IDX_W-1:0] feed_idx;
  word_t            next_id_nxt;
  slot_view_t       view;
  slot_eval_t       ev;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;

  // Lowest-numbered free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign create_ok = in_fire && (in_req.action == ACT_CREATE) &&
                     (in_req.timeout_len != '0) && free_found;

  // The id counter skips zero when it wraps.
  assign next_id_nxt = (next_id_r == '1) ? word_t'(1) : next_id_r + word_t'(1);

  // Read address of the scan; parked at zero once the table is covered.
  assign rd_addr = (scan_cnt_r != SCAN_LAST) ? scan_cnt_r[IDX_W-1:0] : '0;

  // Shared slot evaluator.
  assign view = '{valid: rd_valid_bit_r, id: rd_id_r, timeout: rd_tmo_r,
                  fed_at: rd_feed_r};

  mcsw_slot_eval u_eval (
    .slot_i      (view),
    .target_id_i (target_r),
    .now_i       (now_r),
    .eval_o      (ev)
  );

  // Fold the slot in the read stage into the running best match.
  always_comb begin
    hit  = rd_vld_r && ((op_r == ACT_CHECK) ? ev.expired : ev.id_match);
    take = hit && (!best_hit_r || (rd_age_r < best_age_r));
    best_hit_nxt = best_hit_r || hit;
    best_idx_nxt = take ? rd_idx_r : best_idx_r;
    best_age_nxt = take ? rd_age_r : best_age_r;
    best_id_nxt  = take ? rd_id_r  : best_id_r;
    exp_cnt_nxt  = (hit && (exp_cnt_r != EXP_CNT_MAX)) ? exp_cnt_r + 4'd1 : exp_cnt_r;
  end

  assign scan_end = (state_r == S_SCAN) && (scan_cnt_r == SCAN_LAST);

  // Feed restamps the newest match; create stamps its new slot.
  assign feed_we  = create_ok || (scan_end && (op_r == ACT_FEED) && best_hit_nxt);
  assign feed_idx = create_ok ? free_idx : best_idx_nxt;

  // Slot memories: one write port each and a registered read port.
  always_ff @(posedge clk) begin
    if (create_ok) begin
      id_mem[free_idx]  <= next_id_r;
      tmo_mem[free_idx] <= in_req.timeout_len;
    end
    if (feed_we) begin
      feed_mem[feed_idx] <= now_r;
    end
    rd_id_r   <= id_mem[rd_addr];
    rd_tmo_r  <= tmo_mem[rd_addr];
    rd_feed_r <= feed_mem[rd_addr];
  end

  // Sequencer, table bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      next_id_r   <= word_t'(1);
      now_r       <= '0;
      scan_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r         <= in_req.action;
            target_r     <= in_req.target_id;
            res_status_r <= ST_OK;
            res_new_id_r <= '0;
            res_cnt_r    <= '0;
            res_eid_r    <= '0;
            scan_cnt_r   <= '0;
            rd_vld_r     <= 1'b0;
            best_hit_r   <= 1'b0;
            exp_cnt_r    <= '0;
            state_r      <= S_DONE;
            unique case (in_req.action)
              ACT_CREATE: begin
                if (in_req.timeout_len == '0) begin
                  res_status_r <= ST_BAD_TIMEOUT;
                end else if (!free_found) begin
                  res_status_r <= ST_FULL;
                end else begin
                  // Every live channel ages by one; the new one is newest.
                  for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (valid_r[i]) begin
                      age_r[i] <= age_r[i] + AGE_ONE;
                    end
                  end
                  age_r[free_idx]   <= '0;
                  valid_r[free_idx] <= 1'b1;
                  res_new_id_r      <= next_id_r;
                  next_id_r         <= next_id_nxt;
                end
              end
              ACT_FEED, ACT_DELETE, ACT_CHECK: begin
                state_r <= S_SCAN;
              end
              ACT_TICK: begin
                now_r <= now_r + word_t'(1);
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          // Issue one slot read per cycle until the table is covered.
          if (scan_cnt_r != SCAN_LAST) begin
            scan_cnt_r     <= scan_cnt_r + SCNT_ONE;
            rd_vld_r       <= 1'b1;
            rd_idx_r       <= rd_addr;
            rd_valid_bit_r <= valid_r[rd_addr];
            rd_age_r       <= age_r[rd_addr];
          end else begin
            rd_vld_r <= 1'b0;
          end
          best_hit_r <= best_hit_nxt;
          best_idx_r <= best_idx_nxt;
          best_age_r <= best_age_nxt;
          best_id_r  <= best_id_nxt;
          exp_cnt_r  <= exp_cnt_nxt;
          // The last slot is in the read stage: settle the request.
          if (scan_end) begin
            state_r <= S_DONE;
            if (op_r == ACT_CHECK) begin
              res_cnt_r <= exp_cnt_nxt;
              res_eid_r <= best_hit_nxt ? best_id_nxt : '0;
            end else if (!best_hit_nxt) begin
              res_status_r <= ST_NOT_FOUND;
            end else if (op_r == ACT_DELETE) begin
              valid_r[best_idx_nxt] <= 1'b0;
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (valid_r[i] && (age_r[i] > best_age_nxt)) begin
                  age_r[i] <= age_r[i] - AGE_ONE;
                end
              end
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_new_id_r <= res_new_id_r;
            out_cnt_r    <= res_cnt_r;
            out_eid_r    <= res_eid_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.new_id        = out_new_id_r;
  assign out_rsp.expired_count = out_cnt_r;
  assign out_rsp.expired_id    = out_eid_r;

  // The id counter never hands out zero.
  `ASSERT_CLK(a_next_id_nonzero, clk, rst_n, next_id_r != '0)
  // The scan never runs past the end of the table.
  `ASSERT_CLK(a_scan_cnt_range, clk, rst_n, scan_cnt_r <= SCAN_LAST)
  // A new id only accompanies a successful create.
  `ASSERT_CLK(a_new_id_only_ok, clk, rst_n, !out_valid_r || out_new_id_r == '0 || out_status_r == ST_OK)
  // A reported expired id implies a non-zero expired count.
  `ASSERT_CLK(a_eid_has_count, clk, rst_n, !out_valid_r || out_eid_r == '0 || out_cnt_r != '0)
  // Feed, delete and check always start a table scan.
  `ASSERT_NEXT(a_scan_op_scans, clk, rst_n, in_fire && (in_req.action == ACT_FEED || in_req.action == ACT_DELETE || in_req.action == ACT_CHECK), state_r == S_SCAN)

endmodule
